[rtl/dsc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared types, constants and helpers for the DSC diversity symbol decoder.
// ----------------------------------------------------------------------------
package dsc_pkg;

  // Default sizing
  localparam int DIVERSITY_DEPTH_DEF = 3;
  localparam int MAX_BYTES_DEF       = 40;

  // Symbol constants
  localparam logic [6:0] STAR_SYMBOL = 7'd42;
  localparam logic [6:0] EOS_SYM_A   = 7'd117;
  localparam logic [6:0] EOS_SYM_B   = 7'd122;
  localparam logic [6:0] EOS_SYM_C   = 7'd127;
  localparam logic [6:0] FILL_RX_SYM1 = 7'd106;
  localparam logic [6:0] FILL_RX_SYM2 = 7'd105;
  localparam logic [3:0] MAX_PHASE    = 4'd9;

  // Request codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_WORD  = 1'b1;

  // Stored symbol: bit 7 is the bad flag, bad symbols carry zero data
  typedef logic [7:0] sym8_t;

  typedef enum logic [2:0] {
    ST_PHASING,
    ST_FILL_DX,
    ST_FILL_RX,
    ST_RX,
    ST_DX,
    ST_DX_EOS,
    ST_RX_EOS,
    ST_HALT
  } state_t;

  typedef struct packed {
    logic       symbol_valid;
    logic [6:0] symbol_out;
    logic       both_bad;
    logic       message_done;
    logic       overflow;
    logic [7:0] error_count;
  } result_t;

  // Expected phasing symbol with pc phasing symbols still to come (1..9)
  function automatic logic [6:0] phasing_symbol(input logic [3:0] pc);
    logic [6:0] s;
    unique case (pc)
      4'd9:    s = 7'd110;
      4'd7:    s = 7'd109;
      4'd5:    s = 7'd108;
      4'd3:    s = 7'd107;
      4'd1:    s = 7'd106;
      4'd8, 4'd6, 4'd4, 4'd2: s = 7'd125;
      default: s = 7'd106;
    endcase
    return s;
  endfunction

  // Bit-reverse the data bits and check them against the zero count
  function automatic sym8_t word_to_symbol(input logic [9:0] cw);
    logic [6:0] s;
    logic [2:0] zeros;
    s = 7'd0;
    for (int j = 0; j < 7; j++) begin
      s[j] = cw[9-j];
    end
    zeros = 3'(7 - $countones(s));
    if (zeros != cw[2:0]) begin
      return 8'h80;
    end
    return {1'b0, s};
  endfunction

  function automatic logic is_eos(input logic [6:0] s);
    return (s == EOS_SYM_A) || (s == EOS_SYM_B) || (s == EOS_SYM_C);
  endfunction

endpackage
`default_nettype wire

[rtl/dsc_diversity_symbol_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsc_diversity_symbol_decoder
// Maritime selective-calling symbol decoder with DX/RX diversity selection.
//
// Usage:
//   Input channel (in_valid/in_ready): a word is either a start request
//   (req_type 0, with the phasing offset) or a received 10-bit code word.
//   Output channel (out_valid/out_ready): exactly one result word per input
//   word, in order, carrying the selected symbol (when one is due), the
//   end-of-message and overflow flags and the running error count.
//   Results go to the output register, or to the skid register if it is full.
//   Throughput is one word per cycle while in_ready is high; all decoding,
//   selection and bookkeeping is done in one pass from the input handshake to the output stage.
//   A two-entry output stage (output register plus skid register) lets a
//   new word be accepted while a finished result is still waiting; when the
//   receiver stalls, in_ready drops once both entries are full.
//   Reset (rst_n low, synchronous) empties the output stage and puts the
//   decoder in the DX fill state with all counters cleared. The DX buffer
//   holds no reset value; it is always written before it is read.
// ----------------------------------------------------------------------------
module dsc_diversity_symbol_decoder #(
  parameter int DIVERSITY_DEPTH = dsc_pkg::DIVERSITY_DEPTH_DEF,
  parameter int MAX_BYTES       = dsc_pkg::MAX_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_req_type,
  input  wire logic [3:0] in_phase_offset,
  input  wire logic [9:0] in_code_word,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_symbol_valid,
  output logic [6:0]      out_symbol_out,
  output logic            out_both_bad,
  output logic            out_message_done,
  output logic            out_overflow,
  output logic [7:0]      out_error_count
);
  import dsc_pkg::*;

  localparam int BW  = (DIVERSITY_DEPTH > 1) ? $clog2(DIVERSITY_DEPTH) : 1;
  localparam int BCW = $clog2(MAX_BYTES + 2);
  localparam logic [BW-1:0]  LAST_IDX  = BW'(DIVERSITY_DEPTH - 1);
  localparam logic [BCW-1:0] MAX_COUNT = BCW'(MAX_BYTES);

  // Decoder state
  state_t          state_r, state_nxt;
  logic [3:0]      phase_count_r, phase_count_nxt;
  logic [BW-1:0]   buf_index_r, buf_index_nxt;
  logic [BCW-1:0]  byte_count_r, byte_count_nxt;
  logic [7:0]      errors_r, errors_nxt;
  sym8_t           dx_store_r [DIVERSITY_DEPTH];

  // Output stage
  logic            out_valid_r, skid_valid_r;
  result_t         out_data_r, skid_data_r;
  result_t         res;

  logic            push, pop;
  logic            is_word;
  sym8_t           sym;
  sym8_t           dx_sym;
  logic [3:0]      pc_clamp;
  logic [3:0]      off_clamp;
  logic [3:0]      bi_ext;
  logic            dx_write;

  // Diversity selection
  logic [6:0]      sel_sym;
  logic [1:0]      sel_err;
  logic            sel_both;
  logic [BCW-1:0]  bc_inc;
  logic            bc_over;

  logic [1:0]      err_add;
  logic [8:0]      err_sum;

  assign push    = in_valid && in_ready;
  assign pop     = out_valid_r && out_ready;
  assign is_word = (in_req_type == REQ_WORD);
  assign sym     = word_to_symbol(in_code_word);
  assign dx_sym  = dx_store_r[buf_index_r];
  assign bi_ext  = 4'(buf_index_r);
  assign bc_inc  = byte_count_r + BCW'(1);
  assign bc_over = (bc_inc > MAX_COUNT);

  assign pc_clamp  = (phase_count_r < 4'd1 || phase_count_r > MAX_PHASE) ? 4'd1
                                                                          : phase_count_r;
  assign off_clamp = (in_phase_offset > MAX_PHASE) ? MAX_PHASE : in_phase_offset;

  // Pick DX copy, then RX copy, then the star symbol
  always_comb begin
    if (!dx_sym[7]) begin
      sel_sym  = dx_sym[6:0];
      sel_err  = (dx_sym != sym) ? 2'd1 : 2'd0;
      sel_both = 1'b0;
    end else if (!sym[7]) begin
      sel_sym  = sym[6:0];
      sel_err  = 2'd1;
      sel_both = 1'b0;
    end else begin
      sel_sym  = STAR_SYMBOL;
      sel_err  = 2'd2;
      sel_both = 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    if (!is_word) begin
      state_nxt = (off_clamp == 4'd0) ? ST_FILL_DX : ST_PHASING;
    end else begin
      unique case (state_r)
        ST_PHASING: state_nxt = (pc_clamp == 4'd1) ? ST_FILL_DX : ST_PHASING;
        ST_FILL_DX: state_nxt = (buf_index_r == LAST_IDX) ? ST_RX : ST_FILL_RX;
        ST_FILL_RX: state_nxt = ST_FILL_DX;
        ST_RX: begin
          if (bc_over) begin
            state_nxt = ST_HALT;
          end else begin
            state_nxt = is_eos(sel_sym) ? ST_DX_EOS : ST_DX;
          end
        end
        ST_DX:      state_nxt = ST_RX;
        ST_DX_EOS:  state_nxt = ST_RX_EOS;
        ST_RX_EOS:  state_nxt = ST_HALT;
        ST_HALT:    state_nxt = ST_HALT;
        default:    state_nxt = ST_HALT;
      endcase
    end
  end

  // Counters, buffer write and result word
  always_comb begin
    phase_count_nxt = phase_count_r;
    buf_index_nxt   = buf_index_r;
    byte_count_nxt  = byte_count_r;
    err_add         = 2'd0;
    dx_write        = 1'b0;
    res             = '0;
    if (!is_word) begin
      if (off_clamp != 4'd0) begin
        phase_count_nxt = off_clamp;
      end
      buf_index_nxt  = '0;
      byte_count_nxt = '0;
    end else begin
      unique case (state_r)
        ST_PHASING: begin
          if (sym != {1'b0, phasing_symbol(pc_clamp)}) begin
            err_add = 2'd1;
          end
          phase_count_nxt = pc_clamp - 4'd1;
        end
        ST_FILL_DX: begin
          dx_write      = 1'b1;
          buf_index_nxt = (buf_index_r == LAST_IDX) ? '0 : buf_index_r + BW'(1);
        end
        ST_FILL_RX: begin
          if ((bi_ext == 4'd1 && sym != {1'b0, FILL_RX_SYM1}) ||
              (bi_ext == 4'd2 && sym != {1'b0, FILL_RX_SYM2})) begin
            err_add = 2'd1;
          end
        end
        ST_RX, ST_RX_EOS: begin
          err_add          = sel_err;
          byte_count_nxt   = bc_inc;
          res.symbol_valid = 1'b1;
          res.symbol_out   = sel_sym;
          res.both_bad     = sel_both;
          if (state_r == ST_RX_EOS) begin
            res.message_done = 1'b1;
          end else if (bc_over) begin
            res.message_done = 1'b1;
            res.overflow     = 1'b1;
          end
        end
        ST_DX, ST_DX_EOS: begin
          dx_write      = 1'b1;
          buf_index_nxt = (buf_index_r == LAST_IDX) ? '0 : buf_index_r + BW'(1);
        end
        ST_HALT: ;
        default: ;
      endcase
    end
    // Saturating error accumulation
    err_sum    = {1'b0, errors_r} + {7'd0, err_add};
    errors_nxt = !is_word ? 8'd0 : (err_sum[8] ? 8'hFF : err_sum[7:0]);
    res.error_count = errors_nxt;
  end

  // Decoder state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_FILL_DX;
      phase_count_r <= '0;
      buf_index_r   <= '0;
      byte_count_r  <= '0;
      errors_r      <= '0;
    end else if (push) begin
      state_r       <= state_nxt;
      phase_count_r <= phase_count_nxt;
      buf_index_r   <= buf_index_nxt;
      byte_count_r  <= byte_count_nxt;
      errors_r      <= errors_nxt;
    end
  end

  // DX buffer
  always_ff @(posedge clk) begin
    if (push && is_word && dx_write) begin
      dx_store_r[buf_index_r] <= sym;
    end
  end

  // Two-entry output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= push;
      end else begin
        out_valid_r  <= push;
      end
    end else if (!out_valid_r) begin
      out_valid_r <= push;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
        if (push) begin
          skid_data_r <= res;
        end
      end else if (push) begin
        out_data_r <= res;
      end
    end else if (!out_valid_r) begin
      if (push) begin
        out_data_r <= res;
      end
    end else if (push) begin
      skid_data_r <= res;
    end
  end

  assign in_ready         = !skid_valid_r;
  assign out_valid        = out_valid_r;
  assign out_symbol_valid = out_data_r.symbol_valid;
  assign out_symbol_out   = out_data_r.symbol_out;
  assign out_both_bad     = out_data_r.both_bad;
  assign out_message_done = out_data_r.message_done;
  assign out_overflow     = out_data_r.overflow;
  assign out_error_count  = out_data_r.error_count;

endmodule
`default_nettype wire

[rtl/dsc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsc_checker
// Port-level checks on the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module dsc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_symbol_valid,
  input wire logic [6:0] out_symbol_out,
  input wire logic       out_both_bad,
  input wire logic       out_message_done,
  input wire logic       out_overflow,
  input wire logic [7:0] out_error_count
);
  import dsc_pkg::*;

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_symbol_out) &&
      $stable(out_error_count) && $stable(out_message_done))
    else $error("result word changed while stalled");

  // No symbol means empty symbol fields
  a_no_sym: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_symbol_valid |-> out_symbol_out == 7'd0 && !out_both_bad)
    else $error("symbol fields set without a symbol");

  // Overflow always ends the message
  a_ovf_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_message_done && out_symbol_valid)
    else $error("overflow without message end");

  // Both copies bad gives the star symbol and at least two errors
  a_star: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_both_bad |-> out_symbol_valid && out_symbol_out == STAR_SYMBOL &&
      out_error_count >= 8'd2)
    else $error("both-bad result without star symbol");

endmodule

bind dsc_diversity_symbol_decoder dsc_checker u_dsc_checker (.*);
`default_nettype wire

[verif/dsc_diversity_symbol_decoder_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DSC diversity symbol decoder testbench
// Drives start requests and 10-bit code words through the valid/ready input
// channel. Each accepted word is run through a local decoder model, and the
// model's or pinned result is queued. Every result word from the block is
// compared field by field with the oldest queued result. Stimulus is a
// short directed table, then mostly well-formed messages (phasing, DX fill,
// DX/RX pairs, end-of-signal or overflow) with random content and corruption,
// mixed with noise and cut-off messages. Both sides idle at random.
// ----------------------------------------------------------------------------
module dsc_diversity_symbol_decoder_test;
  import dsc_pkg::*;

  localparam int DEPTH         = DIVERSITY_DEPTH_DEF;
  localparam int MAX_LEN       = MAX_BYTES_DEF;
  localparam int DIRECTED_ROWS = 25;
  localparam int TARGET_WORDS  = 1775;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 10;
  localparam int REPORT_CAP    = 40;

  localparam sym8_t BAD_MARK = 8'h80;
  localparam logic [6:0] SYNC_SEQ [9] = '{7'd110, 7'd125, 7'd109, 7'd125, 7'd108,
                                          7'd125, 7'd107, 7'd125, 7'd106};
  localparam logic [6:0] END_SYMS [3] = '{EOS_SYM_A, EOS_SYM_B, EOS_SYM_C};

  localparam result_t NO_RESULT = '0;
  localparam result_t ONE_ERROR = '{symbol_valid: 1'b0, symbol_out: 7'd0, both_bad: 1'b0,
                                    message_done: 1'b0, overflow: 1'b0, error_count: 8'd1};

  typedef struct packed {
    logic       req;
    logic [3:0] offset;
    logic [9:0] word;
    logic       pinned;
    result_t    want;
  } dir_row_t;

  // DUT ports
  logic       clk             = 1'b0;
  logic       rst_n           = 1'b0;
  logic       in_valid        = 1'b0;
  logic       in_ready;
  logic       in_req_type     = REQ_WORD;
  logic [3:0] in_phase_offset = '0;
  logic [9:0] in_code_word    = '0;
  logic       out_valid;
  logic       out_ready       = 1'b0;
  logic       out_symbol_valid;
  logic [6:0] out_symbol_out;
  logic       out_both_bad;
  logic       out_message_done;
  logic       out_overflow;
  logic [7:0] out_error_count;

  // side band travelling with each input word: a hand-typed result, if any
  logic    row_pinned = 1'b0;
  result_t row_result = '0;

  // decoder model state
  state_t pr_state      = ST_FILL_DX;
  int     pr_phase_left = 0;
  int     pr_slot       = 0;
  sym8_t  pr_dx [DEPTH] = '{default: '0};
  int     pr_bytes      = 0;
  int     pr_errs       = 0;

  result_t     due_results [$];
  int          sent_count   = 0;
  int          fail_count   = 0;
  int          report_count = 0;
  int          n_checked    = 0;
  int          n_symbols    = 0;
  int          n_both_bad   = 0;
  int          n_done       = 0;
  int          n_overflow   = 0;
  int unsigned cycle_count  = 0;

  dsc_diversity_symbol_decoder #(
    .DIVERSITY_DEPTH(DEPTH),
    .MAX_BYTES      (MAX_LEN)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_phase_offset (in_phase_offset),
    .in_code_word    (in_code_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_symbol_valid(out_symbol_valid),
    .out_symbol_out  (out_symbol_out),
    .out_both_bad    (out_both_bad),
    .out_message_done(out_message_done),
    .out_overflow    (out_overflow),
    .out_error_count (out_error_count)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Symbol -> code word: data bits reversed into 9..3, zero count in 2..0
  function automatic logic [9:0] encode_symbol(input logic [6:0] s);
    logic [9:0] cw;
    cw = '0;
    for (int j = 0; j < 7; j++) cw[9 - j] = s[j];
    cw[2:0] = 3'(7 - $countones(s));
    return cw;
  endfunction

  // Code word -> symbol; a word that does not re-encode to itself is bad
  function automatic sym8_t unpack_word(input logic [9:0] cw);
    logic [6:0] s;
    for (int j = 0; j < 7; j++) s[j] = cw[9 - j];
    return (encode_symbol(s) == cw) ? {1'b0, s} : BAD_MARK;
  endfunction

  function automatic logic is_end_symbol(input logic [6:0] s);
    return s inside {EOS_SYM_A, EOS_SYM_B, EOS_SYM_C};
  endfunction

  function automatic void add_errors(input int n);
    pr_errs = (pr_errs + n > 255) ? 255 : pr_errs + n;
  endfunction

  // Diversity choice between the stored DX copy and the RX repeat
  function automatic logic [6:0] select_copy(input sym8_t dx, input sym8_t rx,
                                             output logic both);
    logic [6:0] pick;
    both = 1'b0;
    if (!dx[7]) begin
      pick = dx[6:0];
      if (dx != rx) add_errors(1);
    end else if (!rx[7]) begin
      pick = rx[6:0];
      add_errors(1);
    end else begin
      pick = STAR_SYMBOL;
      both = 1'b1;
      add_errors(2);
    end
    if (pr_bytes < 255) pr_bytes++;
    return pick;
  endfunction

  // Decoder model: one input word in, one result word out
  function automatic result_t decode_word(input logic req, input logic [3:0] offset,
                                          input logic [9:0] cw);
    result_t r;
    sym8_t   s;
    int      slot;
    int      pc;
    logic    both;
    r = '0;
    if (req == REQ_START) begin
      pc = (offset > MAX_PHASE) ? int'(MAX_PHASE) : int'(offset);
      if (pc == 0) begin
        pr_state = ST_FILL_DX;
      end else begin
        pr_phase_left = pc;
        pr_state = ST_PHASING;
      end
      pr_slot  = 0;
      pr_errs  = 0;
      pr_bytes = 0;
      return r;
    end
    s = unpack_word(cw);
    slot = pr_slot % DEPTH;
    case (pr_state)
      ST_PHASING: begin
        pc = (pr_phase_left < 1 || pr_phase_left > 9) ? 1 : pr_phase_left;
        if (s != {1'b0, SYNC_SEQ[9 - pc]}) add_errors(1);
        pr_phase_left = pc - 1;
        if (pr_phase_left == 0) pr_state = ST_FILL_DX;
      end
      ST_FILL_DX: begin
        pr_dx[slot] = s;
        pr_slot = slot + 1;
        if (pr_slot >= DEPTH) begin
          pr_slot = 0;
          pr_state = ST_RX;
        end else begin
          pr_state = ST_FILL_RX;
        end
      end
      ST_FILL_RX: begin
        if ((pr_slot == 1 && s != {1'b0, FILL_RX_SYM1}) ||
            (pr_slot == 2 && s != {1'b0, FILL_RX_SYM2})) add_errors(1);
        pr_state = ST_FILL_DX;
      end
      ST_RX, ST_RX_EOS: begin
        r.symbol_out   = select_copy(pr_dx[slot], s, both);
        r.symbol_valid = 1'b1;
        r.both_bad     = both;
        if (pr_state == ST_RX_EOS) begin
          r.message_done = 1'b1;
          pr_state = ST_HALT;
        end else begin
          pr_state = is_end_symbol(r.symbol_out) ? ST_DX_EOS : ST_DX;
          if (pr_bytes > MAX_LEN) begin
            r.message_done = 1'b1;
            r.overflow     = 1'b1;
            pr_state = ST_HALT;
          end
        end
      end
      ST_DX, ST_DX_EOS: begin
        pr_dx[slot] = s;
        pr_slot = (slot + 1) % DEPTH;
        pr_state = (pr_state == ST_DX) ? ST_RX : ST_RX_EOS;
      end
      default: ;
    endcase
    r.error_count = pr_errs[7:0];
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap(input bit calm);
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Code word, damaged in pct percent of calls: either a broken zero count or random bits
  function automatic logic [9:0] noisy(input logic [6:0] s, input int pct);
    logic [9:0] cw;
    cw = encode_symbol(s);
    if ($urandom_range(0, 99) < pct) begin
      if ($urandom_range(0, 1)) cw[2:0] = cw[2:0] ^ 3'($urandom_range(1, 7));
      else cw = 10'($urandom);
    end
    return cw;
  endfunction

  // Present one word and hold it until accepted
  task automatic send_word(input logic req, input logic [3:0] offset, input logic [9:0] cw,
                           input logic pinned, input result_t want);
    int idle;
    idle = pick_gap(((sent_count / 200) % 5) == 2);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_phase_offset <= offset;
    in_code_word    <= cw;
    row_pinned      <= pinned;
    row_result      <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  // Hold off the sender until every queued result has come back
  task automatic park_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // One message: start, phasing, DX fill, DX/RX pairs to end-of-signal or overflow
  task automatic send_message();
    logic [9:0] words [$];
    logic [6:0] body [$];
    logic [6:0] s;
    logic [3:0] offset;
    int         phase;
    int         n_sel;
    int         limit;
    bit         ovf_run;
    offset  = ($urandom_range(0, 99) < 12) ? 4'($urandom_range(10, 15))
                                            : 4'($urandom_range(0, 9));
    phase   = (offset > MAX_PHASE) ? int'(MAX_PHASE) : int'(offset);
    ovf_run = ($urandom_range(0, 99) < 15);
    if (ovf_run) n_sel = MAX_LEN + 1;
    else if ($urandom_range(0, 99) < 80) n_sel = $urandom_range(2, 14);
    else n_sel = $urandom_range(15, 41);

    // symbol content; end-of-signal only where intended
    for (int k = 0; k < n_sel + DEPTH - 1; k++) begin
      s = 7'($urandom_range(0, 127));
      while (is_end_symbol(s)) s = 7'($urandom_range(0, 116));
      body.push_back(s);
    end
    if (!ovf_run) body[n_sel - 2] = END_SYMS[$urandom_range(0, 2)];
    else if ($urandom_range(0, 1)) body[MAX_LEN] = END_SYMS[$urandom_range(0, 2)];

    for (int p = phase; p > 0; p--) words.push_back(noisy(SYNC_SEQ[9 - p], 6));
    for (int i = 0; i < DEPTH; i++) begin
      words.push_back(noisy(body[i], 5));
      if (i == 0) words.push_back(noisy(FILL_RX_SYM1, 6));
      if (i == 1 && DEPTH > 2) words.push_back(noisy(FILL_RX_SYM2, 6));
    end
    for (int k = 0; k < n_sel; k++) begin
      words.push_back(noisy(body[k], 10));
      if (k < n_sel - 1) words.push_back(noisy(body[k + DEPTH], 5));
    end

    // some messages are cut short
    limit = words.size();
    if ($urandom_range(0, 99) < 10) limit = $urandom_range(0, words.size() - 1);
    send_word(REQ_START, offset, 10'($urandom), 1'b0, NO_RESULT);
    for (int i = 0; i < limit; i++) send_word(REQ_WORD, 4'($urandom), words[i], 1'b0, NO_RESULT);
  endtask

  // Unstructured words with the odd start request
  task automatic send_noise(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 8)
        send_word(REQ_START, 4'($urandom), 10'($urandom), 1'b0, NO_RESULT);
      else
        send_word(REQ_WORD, 4'($urandom),
                  $urandom_range(0, 1) ? 10'($urandom) : encode_symbol(7'($urandom)),
                  1'b0, NO_RESULT);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      if (report_count < REPORT_CAP) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        report_count++;
      end
    end
  endtask

  // Predict each accepted input word
  always @(posedge clk) begin : word_intake
    result_t predicted;
    if (rst_n && in_valid && in_ready) begin
      predicted = decode_word(in_req_type, in_phase_offset, in_code_word);
      due_results.push_back(row_pinned ? row_result : predicted);
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        fail_count++;
        if (report_count < REPORT_CAP) begin
          $error("result word with no expected result pending");
          report_count++;
        end
      end else begin
        want = due_results.pop_front();
        check_field("symbol_valid", 8'(want.symbol_valid), 8'(out_symbol_valid));
        check_field("symbol_out", 8'(want.symbol_out), 8'(out_symbol_out));
        check_field("both_bad", 8'(want.both_bad), 8'(out_both_bad));
        check_field("message_done", 8'(want.message_done), 8'(out_message_done));
        check_field("overflow", 8'(want.overflow), 8'(out_overflow));
        check_field("error_count", want.error_count, out_error_count);
        n_checked++;
        n_symbols  += int'(want.symbol_valid);
        n_both_bad += int'(want.both_bad);
        n_done     += int'(want.message_done);
        n_overflow += int'(want.overflow);
      end
    end
  end

  // Receiver: ready stretches broken by random stalls, with calm periods
  initial begin : sink_pacing
    int hold;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      hold = pick_gap(((cycle_count / 2500) % 5) == 3);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, due_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t dir_table [DIRECTED_ROWS];
    int       roll;
    dir_table = '{
      '{REQ_START, 4'd15, 10'h000,               1'b1, NO_RESULT}, // oversized offset
      '{REQ_WORD,  4'd0,  10'h3FF,               1'b1, ONE_ERROR}, // bad phasing word
      '{REQ_WORD,  4'd0,  encode_symbol(7'd125), 1'b0, NO_RESULT},
      '{REQ_WORD,  4'd0,  encode_symbol(7'd109), 1'b0, NO_RESULT},
      '{REQ_WORD,  4'd0,  encode_symbol(7'd125), 1'b0, NO_RESULT},
      '{REQ_WORD,  4'd0,  encode_symbol(7'd108), 1'b0, NO_RESULT},
      '{REQ_WORD,  4'd0,  encode_symbol(7'd125), 1'b0, NO_RESULT},
      '{REQ_WORD,  4'd0,  encode_symbol(7'd107), 1'b0, NO_RESULT},
      '{REQ_WORD,  4'd0,  encode_symbol(7'd125), 1'b0, NO_RESULT},
      '{REQ_WORD,  4'd0,  encode_symbol(7'd106), 1'b0, NO_RESULT},
      '{REQ_WORD,  4'd0,  encode_symbol(7'd0),   1'b1, ONE_ERROR}, // DX fill, symbol 0
      '{REQ_WORD,  4'd0,  encode_symbol(7'd105), 1'b0, NO_RESULT}, // wrong RX phasing
      '{REQ_WORD,  4'd0,  10'h000,               1'b0, NO_RESULT}, // bad DX
      '{REQ_WORD,  4'd0,  encode_symbol(7'd105), 1'b0, NO_RESULT},
      '{REQ_WORD,  4'd0,  encode_symbol(7'd127), 1'b0, NO_RESULT}, // DX end-of-signal
      '{REQ_WORD,  4'd0,  encode_symbol(7'd1),   1'b0, NO_RESULT}, // DX wins, RX differs
      '{REQ_WORD,  4'd0,  10'h000,               1'b0, NO_RESULT},
      '{REQ_WORD,  4'd0,  10'h3FF,               1'b0, NO_RESULT}, // both copies bad
      '{REQ_WORD,  4'd0,  encode_symbol(7'd3),   1'b0, NO_RESULT},
      '{REQ_WORD,  4'd0,  encode_symbol(7'd127), 1'b0, NO_RESULT}, // end-of-signal pair
      '{REQ_WORD,  4'd0,  encode_symbol(7'd9),   1'b0, NO_RESULT},
      '{REQ_WORD,  4'd0,  encode_symbol(7'd66),  1'b0, NO_RESULT}, // RX wins, message ends
      '{REQ_WORD,  4'd0,  encode_symbol(7'd117), 1'b0, NO_RESULT}, // ignored after end
      '{REQ_START, 4'd0,  10'h3FF,               1'b1, NO_RESULT}, // straight to fill
      '{REQ_WORD,  4'd15, encode_symbol(7'd122), 1'b0, NO_RESULT}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_table[i])
      send_word(dir_table[i].req, dir_table[i].offset, dir_table[i].word,
                dir_table[i].pinned, dir_table[i].want);
    park_until_drained();

    // random messages and noise
    while (sent_count < TARGET_WORDS) begin
      roll = $urandom_range(0, 99);
      if (roll < 82) send_message();
      else send_noise($urandom_range(1, 10));
      if ($urandom_range(0, 99) < 4) park_until_drained();
    end

    park_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d input words sent, %0d result words checked in %0d cycles",
             sent_count, n_checked, cycle_count);
    $display("%0d symbols selected (%0d both bad), %0d messages ended, %0d by overflow",
             n_symbols, n_both_bad, n_done, n_overflow);
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[dsc_diversity_symbol_decoder.f]
rtl/dsc_pkg.sv
rtl/dsc_diversity_symbol_decoder.sv
rtl/dsc_checker.sv
verif/dsc_diversity_symbol_decoder_test.sv
